// ===== design/hslca_pkg.sv =====
// ----------------------------------------------------------------------------
// hslca_pkg
// Shared types and fixed-point constants of the role-based HSL color adapter.
// ----------------------------------------------------------------------------
package hslca_pkg;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [1:0] func;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} pix_out_t;

	localparam logic [1:0] ROLE_TEXT   = 2'd0;
	localparam logic [1:0] ROLE_BACK   = 2'd1;
	localparam logic [1:0] ROLE_BORDER = 2'd2;
	localparam logic [1:0] ROLE_OTHER  = 2'd3;

	// divider geometry: numerator, divisor and quotient widths
	localparam int DIV_NW = 27;
	localparam int DIV_DW = 11;
	localparam int DIV_QW = 17;

	// 2**32 / 255, rounded up; exact floor division for numerators below 2**24
	localparam logic [24:0] L_RECIP = 25'd16843010;

	localparam logic [16:0] K_012   = 17'd7864;
	localparam logic [16:0] K_004   = 17'd2621;
	localparam logic [16:0] K_075   = 17'd49152;
	localparam logic [16:0] K_005   = 17'd3277;
	localparam logic [16:0] K_013   = 17'd8520;
	localparam logic [16:0] K_008   = 17'd5243;
	localparam logic [16:0] K_010   = 17'd6554;
	localparam logic [16:0] K_030   = 17'd19661;
	localparam logic [16:0] K_045   = 17'd29491;
	localparam logic [16:0] K_068   = 17'd44564;
	localparam logic [16:0] K_105   = 17'd68813;
	localparam logic [15:0] K_THIRD = 16'd21845;

	localparam logic [1:0] SEL_RAMP = 2'd0;
	localparam logic [1:0] SEL_Q    = 2'd1;
	localparam logic [1:0] SEL_P    = 2'd2;

endpackage

// ===== design/role_based_hsl_color_adapter.sv =====
// ----------------------------------------------------------------------------
// role_based_hsl_color_adapter
// RGB to HSL, role-based adjustment of saturation and lightness, HSL to RGB.
// ----------------------------------------------------------------------------
//  channel  signals                         payload
//  color    color_valid, color_stall, color pix_in_t  (red, green, blue, role)
//  result   result_valid, result_stall,     pix_out_t (red, green, blue)
//           result
//
//  One color per cycle while the result is not stalled; a color passes through
//  25 register stages (two front stages, 17 divider stages, six back stages
//  including the output register).
//  All stages advance together; a stalled result freezes the whole pipeline,
//  and color_stall follows at once.
//  Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module role_based_hsl_color_adapter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                color_valid,
	output logic                color_stall,
	input  hslca_pkg::pix_in_t  color,
	output logic                result_valid,
	input  logic                result_stall,
	output hslca_pkg::pix_out_t result
);
	import hslca_pkg::*;

	logic en;
	assign en          = !(result_valid && result_stall);
	assign color_stall = !en;

	// stage 1: capture
	logic    v_s1;
	pix_in_t pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= color_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1 <= color;
		end
	end

	// stage 2: max, min, hue numerator, divider operands
	logic [7:0]  r1, g1, b1, mx, mn, dd;
	logic [8:0]  sum;
	logic [10:0] hn, dens, d6;

	always_comb begin
		r1 = pix_s1.red_in;
		g1 = pix_s1.green_in;
		b1 = pix_s1.blue_in;
		mx = r1;
		mn = r1;
		if (g1 > mx) mx = g1;
		if (b1 > mx) mx = b1;
		if (g1 < mn) mn = g1;
		if (b1 < mn) mn = b1;
		sum = {1'b0, mx} + {1'b0, mn};
		dd  = mx - mn;
		d6  = 11'(dd) * 11'd6;
		dens = (sum > 9'd255) ? 11'(10'd510 - {1'b0, sum}) : 11'(sum);
		if (mx == r1)
			hn = 11'(g1) - 11'(b1) + ((g1 < b1) ? d6 : 11'd0);
		else if (mx == g1)
			hn = 11'(b1) - 11'(r1) + 11'({dd, 1'b0});
		else
			hn = 11'(r1) - 11'(g1) + 11'({dd, 2'b00});
	end

	logic                v_s2, gray_s2;
	logic [1:0]          role_s2;
	logic [8:0]          sum_s2;
	logic [DIV_NW-1:0]   ns_s2, nh_s2;
	logic [DIV_DW-1:0]   ds_s2, dh_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			gray_s2 <= (dd == 8'd0);
			role_s2 <= pix_s1.func;
			sum_s2  <= sum;
			ns_s2   <= {3'b000, dd, 6'd0, dens[10:1]};
			ds_s2   <= dens;
			nh_s2   <= {hn, 16'(10'(dd) * 10'd3)};
			dh_s2   <= d6;
		end
	end

	// lightness: (sum * 32768 + 127) / 255 by reciprocal multiplication
	logic [23:0] lx2;
	logic [48:0] lp2;
	logic [16:0] lq2;

	assign lx2 = {sum_s2, 15'd127};
	assign lp2 = 49'(lx2) * 49'(L_RECIP);
	assign lq2 = lp2[48:32];

	// divider stages
	logic [DIV_QW-1:0] qs, qh;

	hslca_div u_div_s (.clk(clk), .en(en), .num(ns_s2), .den(ds_s2), .quo(qs));
	hslca_div u_div_h (.clk(clk), .en(en), .num(nh_s2), .den(dh_s2), .quo(qh));

	logic        v_sd    [DIV_QW];
	logic        gray_sd [DIV_QW];
	logic [1:0]  role_sd [DIV_QW];
	logic [16:0] l_sd    [DIV_QW];

	for (genvar k = 0; k < DIV_QW; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k] <= 1'b0;
			end else if (en) begin
				v_sd[k] <= (k == 0) ? v_s2 : v_sd[(k == 0) ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				gray_sd[k] <= (k == 0) ? gray_s2 : gray_sd[(k == 0) ? 0 : k-1];
				role_sd[k] <= (k == 0) ? role_s2 : role_sd[(k == 0) ? 0 : k-1];
				l_sd[k]    <= (k == 0) ? lq2 : l_sd[(k == 0) ? 0 : k-1];
			end
		end
	end

	// stage 3: first role adjustment
	logic [15:0] h0, s0, l0, s3n, l3n;
	logic [16:0] k3;
	logic [32:0] p3;
	logic [17:0] m3, a3;
	logic [1:0]  role3;

	always_comb begin
		role3 = role_sd[DIV_QW-1];
		h0 = gray_sd[DIV_QW-1] ? 16'd0 : qh[15:0];
		s0 = gray_sd[DIV_QW-1] ? 16'd0 : (qs[16] ? 16'hFFFF : qs[15:0]);
		l0 = l_sd[DIV_QW-1][16] ? 16'hFFFF : l_sd[DIV_QW-1][15:0];
		k3 = (role3 == ROLE_TEXT) ? K_105 : K_075;
		p3 = {17'd0, s0} * {16'd0, k3};
		m3 = 18'((p3 + 33'd32768) >> 16);
		a3 = m3 + ((role3 == ROLE_BACK) ? 18'(K_005) : 18'(K_010));
		s3n = s0;
		l3n = l0;
		case (role3)
			ROLE_TEXT: begin
				if (l0 < K_045[15:0]) l3n = K_068[15:0];
				if (s0 > K_010[15:0]) s3n = (a3 > 18'd65535) ? 16'hFFFF : a3[15:0];
			end
			ROLE_BACK, ROLE_BORDER: begin
				s3n = (a3 > 18'd65535) ? 16'hFFFF : a3[15:0];
			end
			default: begin
				s3n = s0;
			end
		endcase
	end

	logic        v_s3, boost_s3;
	logic [1:0]  role_s3;
	logic [15:0] h_s3, s_s3, l_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_sd[DIV_QW-1];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			role_s3  <= role3;
			boost_s3 <= (s0 > K_012[15:0]);
			h_s3     <= h0;
			s_s3     <= s3n;
			l_s3     <= l3n;
		end
	end

	// stage 4: lightness from adjusted saturation
	logic [32:0] p4;
	logic [17:0] m4, a4;
	logic [15:0] l4n;

	always_comb begin
		p4 = {17'd0, s_s3} * {16'd0, ((role_s3 == ROLE_BACK) ? K_008 : K_005)};
		m4 = 18'((p4 + 33'd32768) >> 16);
		if (role_s3 == ROLE_BACK)
			a4 = 18'(K_013) + (boost_s3 ? 18'(K_004) : 18'd0) + m4;
		else
			a4 = 18'(K_030) + m4;
		case (role_s3)
			ROLE_BACK, ROLE_BORDER: l4n = (a4 > 18'd65535) ? 16'hFFFF : a4[15:0];
			default:                l4n = l_s3;
		endcase
	end

	logic        v_s4;
	logic [15:0] h_s4, s_s4, l_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			h_s4 <= h_s3;
			s_s4 <= s_s3;
			l_s4 <= l4n;
		end
	end

	// stage 5: q, p and channel hue offsets
	logic [31:0] p5;
	logic [15:0] ls5;
	logic [17:0] q5;
	logic [18:0] pp5;

	always_comb begin
		p5  = {16'd0, l_s4} * {16'd0, s_s4};
		ls5 = 16'((p5 + 32'd32768) >> 16);
		if (!l_s4[15])
			q5 = 18'(l_s4) + 18'(ls5);
		else
			q5 = 18'(l_s4) + 18'(s_s4) - 18'(ls5);
		pp5 = 19'({l_s4, 1'b0}) - 19'(q5);
	end

	logic               v_s5;
	logic [17:0]        q_s5;
	logic signed [18:0] p_s5;
	logic [15:0]        t_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			q_s5    <= q5;
			p_s5    <= pp5;
			t_s5[0] <= h_s4 + K_THIRD;
			t_s5[1] <= h_s4;
			t_s5[2] <= h_s4 - K_THIRD;
		end
	end

	// stage 6: ramp products
	logic [18:0] qp6;
	logic [18:0] t6   [3];
	logic [16:0] f6   [3];
	logic [1:0]  sel6 [3];

	always_comb begin
		qp6 = 19'(q_s5) - p_s5;
		for (int c = 0; c < 3; c++) begin
			t6[c] = 19'(t_s5[c]) * 19'd6;
			f6[c] = 17'd0;
			if (t6[c] < 19'd65536) begin
				sel6[c] = SEL_RAMP;
				f6[c]   = t6[c][16:0];
			end else if (!t_s5[c][15]) begin
				sel6[c] = SEL_Q;
			end else if (18'(t_s5[c]) * 18'd3 < 18'd131072) begin
				sel6[c] = SEL_RAMP;
				f6[c]   = 17'(19'd262144 - t6[c]);
			end else begin
				sel6[c] = SEL_P;
			end
		end
	end

	logic               v_s6;
	logic [17:0]        q_s6;
	logic signed [18:0] p_s6;
	logic [34:0]        prod_s6 [3];
	logic [1:0]         sel_s6  [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			q_s6 <= q_s5;
			p_s6 <= p_s5;
			for (int c = 0; c < 3; c++) begin
				prod_s6[c] <= {17'd0, qp6[17:0]} * {18'd0, f6[c]};
				sel_s6[c]  <= sel6[c];
			end
		end
	end

	// stage 7: channel value, clamp
	logic signed [20:0] c7  [3];
	logic [15:0]        cc7 [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			case (sel_s6[c])
				SEL_RAMP: c7[c] = 21'(p_s6) + 21'((prod_s6[c] + 35'd32768) >> 16);
				SEL_Q:    c7[c] = 21'(q_s6);
				default:  c7[c] = 21'(p_s6);
			endcase
			if (c7[c] < 0)
				cc7[c] = 16'd0;
			else if (c7[c] > 21'sd65535)
				cc7[c] = 16'hFFFF;
			else
				cc7[c] = c7[c][15:0];
		end
	end

	logic        v_s7;
	logic [15:0] cc_s7 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) cc_s7[c] <= cc7[c];
		end
	end

	// stage 8: scale to 8 bits, output register
	logic [23:0] sc8 [3];
	logic [7:0]  o8  [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sc8[c] = 24'(cc_s7[c]) * 24'd255 + 24'd32768;
			o8[c]  = (sc8[c][23:16] == 8'hFF) ? 8'hFF : sc8[c][23:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= v_s7;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			result.red_out   <= o8[0];
			result.green_out <= o8[1];
			result.blue_out  <= o8[2];
		end
	end

endmodule

// ===== design/hslca_div.sv =====
// ----------------------------------------------------------------------------
// hslca_div
// Pipelined restoring divider, one quotient bit per stage. Expects
// num < den * 2**DIV_QW.
// ----------------------------------------------------------------------------
module hslca_div (
	input  logic                           clk,
	input  logic                           en,
	input  logic [hslca_pkg::DIV_NW-1:0]   num,
	input  logic [hslca_pkg::DIV_DW-1:0]   den,
	output logic [hslca_pkg::DIV_QW-1:0]   quo
);
	import hslca_pkg::*;

	logic [DIV_DW-1:0] rem_s [DIV_QW];
	logic [DIV_DW-1:0] den_s [DIV_QW];
	logic [DIV_QW-1:0] wrk_s [DIV_QW];

	for (genvar k = 0; k < DIV_QW; k++) begin : g_stage
		logic [DIV_DW-1:0] rem_i;
		logic [DIV_DW-1:0] den_i;
		logic [DIV_QW-1:0] wrk_i;
		logic [DIV_DW:0]   trial;
		logic              take;

		if (k == 0) begin : g_first
			assign rem_i = DIV_DW'(num[DIV_NW-1:DIV_QW]);
			assign den_i = den;
			assign wrk_i = num[DIV_QW-1:0];
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
			assign wrk_i = wrk_s[k-1];
		end

		assign trial = {rem_i, wrk_i[DIV_QW-1]};
		assign take  = trial >= {1'b0, den_i};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? DIV_DW'(trial - {1'b0, den_i}) : trial[DIV_DW-1:0];
				den_s[k] <= den_i;
				wrk_s[k] <= {wrk_i[DIV_QW-2:0], take};
			end
		end
	end

	assign quo = wrk_s[DIV_QW-1];

endmodule

// ===== sim/tb_role_based_hsl_color_adapter.sv =====
// ----------------------------------------------------------------------------
// tb_role_based_hsl_color_adapter
// Drives colors with every role through the adapter under random idling on
// both channels (none in the last random phase) and compares each result
// transfer against a table value or a fixed-point HSL round-trip predictor;
// a short table of directed colors comes first.
`timescale 1ns / 100ps

module tb_role_based_hsl_color_adapter;
	import hslca_pkg::*;

	localparam int      LATENCY    = 25;
	localparam int      N_RANDOM   = 800;
	localparam int      N_DIRECTED = 22;
	localparam longint  ONE        = 65536;
	localparam longint  MAXQ       = 65535;

	typedef struct {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [1:0] role;
		logic       known;
		pix_out_t   res;
	} dir_row_t;

	logic     clk;
	logic     arst_n;
	logic     color_valid;
	logic     color_stall;
	pix_in_t  color;
	logic     result_valid;
	logic     result_stall;
	pix_out_t result;

	pix_out_t pending_colors[$];
	dir_row_t dir_rows[N_DIRECTED];
	int       mismatches;
	int       send_idle_pct;
	int       recv_idle_pct;

	role_based_hsl_color_adapter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.color_valid  (color_valid),
		.color_stall  (color_stall),
		.color        (color),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("status: fail");
		$finish;
	end

	function automatic longint clampq(longint v);
		if (v < 0)
			return 0;
		if (v > MAXQ)
			return MAXQ;
		return v;
	endfunction

	function automatic longint round_div(longint num, longint den);
		if (num >= 0)
			return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	function automatic longint mul_q16(longint a, longint b);
		return round_div(a * b, ONE);
	endfunction

	function automatic longint ramp_channel(longint p, longint q, longint t);
		if (6 * t < ONE)
			return p + round_div((q - p) * 6 * t, ONE);
		if (2 * t < ONE)
			return q;
		if (3 * t < 2 * ONE)
			return p + round_div((q - p) * (4 * ONE - 6 * t), ONE);
		return p;
	endfunction

	function automatic logic [7:0] q16_to_byte(longint c);
		longint v;
		v = (clampq(c) * 255 + ONE / 2) / ONE;
		if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	function automatic pix_out_t adapt_color(pix_in_t px);
		longint   r, g, b, mx, mn, d, sum, num, h, s, l, q, p, boost;
		longint   cr, cg, cb;
		pix_out_t o;
		r = longint'(px.red_in);
		g = longint'(px.green_in);
		b = longint'(px.blue_in);
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		sum = mx + mn;
		l = clampq(round_div(sum * ONE, 510));
		h = 0;
		s = 0;
		if (mx != mn) begin
			d = mx - mn;
			if (sum > 255)
				s = clampq(round_div(d * ONE, 510 - sum));
			else
				s = clampq(round_div(d * ONE, sum));
			if (mx == r)
				num = (g - b) + (g < b ? 6 * d : 0);
			else if (mx == g)
				num = (b - r) + 2 * d;
			else
				num = (r - g) + 4 * d;
			h = round_div(num * ONE, 6 * d) & MAXQ;
		end
		case (px.func)
			ROLE_BACK: begin
				boost = (s > longint'(K_012)) ? longint'(K_004) : longint'(0);
				s = clampq(mul_q16(s, longint'(K_075)) + longint'(K_005));
				l = clampq(longint'(K_013) + boost + mul_q16(s, longint'(K_008)));
			end
			ROLE_BORDER: begin
				s = clampq(mul_q16(s, longint'(K_075)) + longint'(K_010));
				l = clampq(longint'(K_030) + mul_q16(s, longint'(K_005)));
			end
			ROLE_TEXT: begin
				if (l < longint'(K_045))
					l = longint'(K_068);
				if (s > longint'(K_010))
					s = clampq(mul_q16(s, longint'(K_105)) + longint'(K_010));
			end
			default: ;
		endcase
		if (s == 0) begin
			cr = l;
			cg = l;
			cb = l;
		end else begin
			if (2 * l < ONE)
				q = l + mul_q16(l, s);
			else
				q = l + s - mul_q16(l, s);
			p = 2 * l - q;
			cr = ramp_channel(p, q, (h + longint'(K_THIRD)) & MAXQ);
			cg = ramp_channel(p, q, h);
			cb = ramp_channel(p, q, (h - longint'(K_THIRD)) & MAXQ);
		end
		o.red_out = q16_to_byte(cr);
		o.green_out = q16_to_byte(cg);
		o.blue_out = q16_to_byte(cb);
		return o;
	endfunction

	function automatic dir_row_t mk_row(int r, int g, int b, logic [1:0] role,
		logic known, int er, int eg, int eb);
		dir_row_t row;
		row.r = 8'(r);
		row.g = 8'(g);
		row.b = 8'(b);
		row.role = role;
		row.known = known;
		row.res = '{red_out: 8'(er), green_out: 8'(eg), blue_out: 8'(eb)};
		return row;
	endfunction

	task automatic send_color(pix_in_t px, logic known, pix_out_t res);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			color_valid <= 1'b0;
			@(posedge clk);
		end
		color_valid <= 1'b1;
		color <= px;
		pending_colors = {pending_colors, (known ? res : adapt_color(px))};
		@(posedge clk);
		while (color_stall)
			@(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (pending_colors.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer %h", result);
				end else begin
					if (result !== pending_colors[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h actual %h",
								pending_colors[0], result);
					end
					void'(pending_colors.pop_front());
				end
			end
			result_stall <= (recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
		end
	end

	initial begin
		pix_in_t px;
		int      phase, wait_cycles;
		mismatches = 0;
		send_idle_pct = 32;
		recv_idle_pct = 48;
		arst_n = 1'b0;
		color_valid = 1'b0;
		color = '0;

		dir_rows[0]  = mk_row(0, 0, 0, ROLE_OTHER, 1'b1, 0, 0, 0);
		dir_rows[1]  = mk_row(255, 255, 255, ROLE_OTHER, 1'b1, 255, 255, 255);
		dir_rows[2]  = mk_row(255, 0, 0, ROLE_OTHER, 1'b1, 255, 0, 0);
		dir_rows[3]  = mk_row(0, 255, 0, ROLE_OTHER, 1'b1, 0, 255, 0);
		dir_rows[4]  = mk_row(0, 0, 255, ROLE_OTHER, 1'b1, 0, 0, 255);
		dir_rows[5]  = mk_row(0, 0, 0, ROLE_TEXT, 1'b0, 0, 0, 0);
		dir_rows[6]  = mk_row(255, 255, 255, ROLE_TEXT, 1'b0, 0, 0, 0);
		dir_rows[7]  = mk_row(255, 0, 0, ROLE_TEXT, 1'b0, 0, 0, 0);
		dir_rows[8]  = mk_row(0, 0, 0, ROLE_BACK, 1'b0, 0, 0, 0);
		dir_rows[9]  = mk_row(255, 255, 0, ROLE_BACK, 1'b0, 0, 0, 0);
		dir_rows[10] = mk_row(128, 128, 128, ROLE_BACK, 1'b0, 0, 0, 0);
		dir_rows[11] = mk_row(0, 0, 0, ROLE_BORDER, 1'b0, 0, 0, 0);
		dir_rows[12] = mk_row(255, 0, 255, ROLE_BORDER, 1'b0, 0, 0, 0);
		dir_rows[13] = mk_row(255, 0, 1, ROLE_BORDER, 1'b0, 0, 0, 0);
		dir_rows[14] = mk_row(200, 200, 10, ROLE_TEXT, 1'b0, 0, 0, 0);
		dir_rows[15] = mk_row(10, 200, 200, ROLE_OTHER, 1'b0, 0, 0, 0);
		dir_rows[16] = mk_row(255, 0, 0, ROLE_BACK, 1'b0, 0, 0, 0);
		dir_rows[17] = mk_row(128, 127, 127, ROLE_TEXT, 1'b0, 0, 0, 0);
		dir_rows[18] = mk_row(255, 0, 0, ROLE_BACK, 1'b0, 0, 0, 0);
		dir_rows[19] = mk_row(140, 134, 134, ROLE_BACK, 1'b0, 0, 0, 0);
		dir_rows[20] = mk_row(1, 0, 0, ROLE_TEXT, 1'b0, 0, 0, 0);
		dir_rows[21] = mk_row(254, 255, 254, ROLE_OTHER, 1'b0, 0, 0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			px.red_in = dir_rows[i].r;
			px.green_in = dir_rows[i].g;
			px.blue_in = dir_rows[i].b;
			px.func = dir_rows[i].role;
			send_color(px, dir_rows[i].known, dir_rows[i].res);
		end

		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = phase == 0 ? 32 : (phase == 1 ? 48 : 0);
			recv_idle_pct = phase == 0 ? 48 : (phase == 1 ? 32 : 0);
			for (int n = 0; n < N_RANDOM / 3; n++) begin
				px = 26'($urandom);
				if ($urandom_range(3, 0) == 0) begin
					px.green_in = px.red_in;
					if ($urandom_range(1, 0))
						px.blue_in = px.red_in;
				end
				send_color(px, 1'b0, '0);
			end
		end
		color_valid <= 1'b0;

		wait_cycles = 0;
		while (pending_colors.size() > 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 5) @(posedge clk);
		if (mismatches == 0 && pending_colors.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
design/hslca_pkg.sv
design/hslca_div.sv
design/role_based_hsl_color_adapter.sv
sim/tb_role_based_hsl_color_adapter.sv
